/* hdl/sos_pkg.sv */
// ----------------------------------------------------------------------------
// sos_pkg: shared types and constants of the spent output set
// Sizes, word layouts, op and status codes, controller commands and states.
// ----------------------------------------------------------------------------
package sos_pkg;

	localparam int LIVE_ENTRIES   = 256;
	localparam int STAGED_ENTRIES = 32;
	localparam int NUM_CHAINS     = 8;

	localparam int LW = (LIVE_ENTRIES > 1) ? $clog2(LIVE_ENTRIES) : 1;
	localparam int SW = (STAGED_ENTRIES > 1) ? $clog2(STAGED_ENTRIES) : 1;
	localparam int CW = $clog2(STAGED_ENTRIES + 1);

	localparam int CHAIN_W = 3;
	localparam int KEY_W   = 4 * 64 + 32;
	localparam int ENTRY_W = KEY_W + CHAIN_W;

	localparam logic [3:0] CONF_NONE = 4'(NUM_CHAINS);

	typedef enum logic [2:0] {
		OP_RECORD = 3'd0,
		OP_REVERT = 3'd1,
		OP_QUERY  = 3'd2,
		OP_STAGE  = 3'd3,
		OP_PUBLISH = 3'd4,
		OP_BEGIN  = 3'd5
	} op_t;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_CONFLICT   = 2'd1,
		ST_LIVE_FULL  = 2'd2,
		ST_STAGE_FULL = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_LSCAN,
		S_DECIDE,
		S_SSCAN,
		S_SDEC,
		S_PUB_RD,
		S_PUB_LD,
		S_PUB_SCAN,
		S_PUB_DEC
	} state_t;

	typedef struct packed {
		logic [2:0]  op;
		logic [63:0] txid_word0;
		logic [63:0] txid_word1;
		logic [63:0] txid_word2;
		logic [63:0] txid_word3;
		logic [31:0] output_index;
		logic [2:0]  chain_id;
	} req_t;

	typedef struct packed {
		logic [1:0] status;
		logic       is_spent;
		logic [3:0] confirming_chain;
	} rsp_t;

	// controller to datapath
	typedef struct packed {
		logic    load_in;
		logic    lscan;
		logic    sscan;
		logic    live_wr;
		logic    live_clr;
		logic    stage_wr;
		logic    pub_init;
		logic    pub_ld;
		logic    pub_next;
		logic    set_flag;
		logic    begin_att;
		logic    respond;
		logic    query;
		status_t status;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic ldone;
		logic lfound;
		logic lfree;
		logic sdone;
		logic sfound;
		logic sfull;
		logic sempty;
		logic pub_more;
		logic flag;
	} stat_t;

endpackage

/* hdl/sos_ram.sv */
// ----------------------------------------------------------------------------
// sos_ram: generic single write, single read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module sos_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                         clk,
	input  logic                                         we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                             wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                             rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* hdl/sos_dp.sv */
// ----------------------------------------------------------------------------
// sos_dp: datapath of the spent output set
// Key register, live and staged tables, scan engines and result register.
// ----------------------------------------------------------------------------
module sos_dp
	import sos_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  req_t  req,
	input  cmd_t  cmd,
	output stat_t stat,
	output logic  strobe,
	output rsp_t  rsp
);

	localparam logic [LW-1:0] LIVE_LAST = LW'(LIVE_ENTRIES - 1);
	localparam logic [CW-1:0] STAGED_MAX = CW'(STAGED_ENTRIES);

	logic [KEY_W-1:0]     key_q;
	logic [CHAIN_W-1:0]   chain_q;
	logic [LIVE_ENTRIES-1:0] valid_q;

	logic [ENTRY_W-1:0] lrdata, srdata;

	logic [LW-1:0] lcnt_q, laddr_s1, hit_slot_q, free_q;
	logic          lrun_q, l_s1, lfound_q, lfree_q;
	logic [CHAIN_W-1:0] hit_chain_q;

	logic [SW-1:0] scnt_q, saddr_s1, sraddr;
	logic          srun_q, s_s1, sfound_q;

	logic [CW-1:0] count_q, pcnt_q;
	logic          flag_q;

	logic lhit, shit, slast_issue, slast_cmp;

	// live table
	sos_ram #(.WIDTH(ENTRY_W), .DEPTH(LIVE_ENTRIES)) u_live (
		.clk  (clk),
		.we   (cmd.live_wr),
		.waddr(free_q),
		.wdata({chain_q, key_q}),
		.raddr(lcnt_q),
		.rdata(lrdata)
	);

	// staging list
	assign sraddr = srun_q ? scnt_q : SW'(pcnt_q);

	sos_ram #(.WIDTH(ENTRY_W), .DEPTH(STAGED_ENTRIES)) u_stage (
		.clk  (clk),
		.we   (cmd.stage_wr),
		.waddr(SW'(count_q)),
		.wdata({chain_q, key_q}),
		.raddr(sraddr),
		.rdata(srdata)
	);

	assign lhit = l_s1 && valid_q[laddr_s1] && (lrdata[KEY_W-1:0] == key_q);
	assign shit = s_s1 && (srdata[KEY_W-1:0] == key_q);
	assign slast_issue = (CW'(scnt_q) + CW'(1)) == count_q;
	assign slast_cmp   = (CW'(saddr_s1) + CW'(1)) == count_q;

	// status to controller
	always_comb begin
		stat.ldone    = l_s1 && (lhit || laddr_s1 == LIVE_LAST);
		stat.lfound   = lfound_q;
		stat.lfree    = lfree_q;
		stat.sdone    = s_s1 && (shit || slast_cmp);
		stat.sfound   = sfound_q;
		stat.sfull    = count_q >= STAGED_MAX;
		stat.sempty   = count_q == '0;
		stat.pub_more = pcnt_q < count_q;
		stat.flag     = flag_q;
	end

	// load key from request or from the staging list
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			key_q   <= {req.txid_word3, req.txid_word2, req.txid_word1,
			            req.txid_word0, req.output_index};
			chain_q <= req.chain_id;
		end else if (cmd.pub_ld) begin
			key_q   <= srdata[KEY_W-1:0];
			chain_q <= srdata[ENTRY_W-1 -: CHAIN_W];
		end
	end

	// live scan: issue reads, compare each read data in the next cycle, stop on a hit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lrun_q   <= 1'b0;
			l_s1     <= 1'b0;
			lfound_q <= 1'b0;
			lfree_q  <= 1'b0;
			lcnt_q   <= '0;
		end else if (cmd.lscan) begin
			lrun_q   <= 1'b1;
			l_s1     <= 1'b0;
			lfound_q <= 1'b0;
			lfree_q  <= 1'b0;
			lcnt_q   <= '0;
		end else begin
			l_s1 <= lrun_q && !lhit;
			if (lrun_q) begin
				lcnt_q <= lcnt_q + LW'(1);
				if (lcnt_q == LIVE_LAST) begin
					lrun_q <= 1'b0;
				end
			end
			if (lhit) begin
				lrun_q   <= 1'b0;
				lfound_q <= 1'b1;
			end
			if (l_s1 && !valid_q[laddr_s1] && !lfree_q) begin
				lfree_q <= 1'b1;
			end
		end
	end

	// scan payload: slot numbers and matched chain
	always_ff @(posedge clk) begin
		laddr_s1 <= lcnt_q;
		if (lhit) begin
			hit_slot_q  <= laddr_s1;
			hit_chain_q <= lrdata[ENTRY_W-1 -: CHAIN_W];
		end
		if (l_s1 && !valid_q[laddr_s1] && !lfree_q) begin
			free_q <= laddr_s1;
		end
		saddr_s1 <= scnt_q;
	end

	// valid bits of the live table
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (cmd.live_wr) begin
			valid_q[free_q] <= 1'b1;
		end else if (cmd.live_clr) begin
			valid_q[hit_slot_q] <= 1'b0;
		end
	end

	// staged scan over entries below the count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			srun_q   <= 1'b0;
			s_s1     <= 1'b0;
			sfound_q <= 1'b0;
			scnt_q   <= '0;
		end else if (cmd.sscan) begin
			srun_q   <= 1'b1;
			s_s1     <= 1'b0;
			sfound_q <= 1'b0;
			scnt_q   <= '0;
		end else begin
			s_s1 <= srun_q && !shit;
			if (srun_q) begin
				scnt_q <= scnt_q + SW'(1);
				if (slast_issue) begin
					srun_q <= 1'b0;
				end
			end
			if (shit) begin
				srun_q   <= 1'b0;
				sfound_q <= 1'b1;
			end
		end
	end

	// staged count, publish cursor and publish flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			pcnt_q  <= '0;
			flag_q  <= 1'b0;
		end else begin
			if (cmd.begin_att) begin
				count_q <= '0;
				flag_q  <= 1'b0;
			end else if (cmd.stage_wr) begin
				count_q <= count_q + CW'(1);
			end
			if (cmd.set_flag) begin
				flag_q <= 1'b1;
			end
			if (cmd.pub_init) begin
				pcnt_q <= '0;
			end else if (cmd.pub_next) begin
				pcnt_q <= pcnt_q + CW'(1);
			end
		end
	end

	// result word: strobe for one cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe <= 1'b0;
		end else begin
			strobe <= cmd.respond;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.respond) begin
			rsp.status           <= cmd.status;
			rsp.is_spent         <= cmd.query && lfound_q;
			rsp.confirming_chain <= (cmd.query && lfound_q) ?
			                        4'(hit_chain_q) : CONF_NONE;
		end
	end

	a_wr_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.live_wr |-> !valid_q[free_q])
		else $error("live write into an occupied slot");
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= STAGED_MAX)
		else $error("staged count beyond capacity");
	a_stage_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.stage_wr |-> count_q < STAGED_MAX)
		else $error("stage write with staging list full");
	a_one_scan: assert property (@(posedge clk) disable iff (!arst_n)
		lrun_q |-> !srun_q)
		else $error("live and staged scans overlap");

endmodule

/* hdl/sos_ctrl.sv */
// ----------------------------------------------------------------------------
// sos_ctrl: controller of the spent output set
// Sequences scans, table updates and publish walk for each command word.
// ----------------------------------------------------------------------------
module sos_ctrl
	import sos_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic [2:0] op,
	input  stat_t      stat,
	output cmd_t       cmd,
	output logic       busy
);

	state_t state_q, state_d;
	op_t    op_q;
	logic   lfull_q;

	// state, latched op and publish overflow mark
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			op_q    <= OP_RECORD;
			lfull_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (start && state_q == S_IDLE) begin
				op_q <= op_t'(op);
			end
			if (cmd.pub_init) begin
				lfull_q <= 1'b0;
			end else if (state_q == S_PUB_DEC && !stat.lfound && !stat.lfree) begin
				lfull_q <= 1'b1;
			end
		end
	end

	assign busy = state_q != S_IDLE;

	// next state and commands
	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		cmd.status = ST_OK;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load_in = 1'b1;
					case (op)
						OP_RECORD, OP_REVERT, OP_QUERY, OP_STAGE: begin
							cmd.lscan = 1'b1;
							state_d   = S_LSCAN;
						end
						OP_PUBLISH: begin
							if (stat.flag) begin
								cmd.respond = 1'b1;
							end else begin
								cmd.pub_init = 1'b1;
								state_d      = S_PUB_RD;
							end
						end
						OP_BEGIN: begin
							cmd.begin_att = 1'b1;
							cmd.respond   = 1'b1;
						end
						default: begin
							cmd.respond = 1'b1;
						end
					endcase
				end
			end
			S_LSCAN: begin
				if (stat.ldone) begin
					state_d = S_DECIDE;
				end
			end
			S_DECIDE: begin
				state_d = S_IDLE;
				case (op_q)
					OP_RECORD: begin
						cmd.respond = 1'b1;
						if (stat.lfound) begin
							cmd.status = ST_CONFLICT;
						end else if (stat.lfree) begin
							cmd.live_wr = 1'b1;
						end else begin
							cmd.status = ST_LIVE_FULL;
						end
					end
					OP_REVERT: begin
						cmd.respond  = 1'b1;
						cmd.live_clr = stat.lfound;
					end
					OP_QUERY: begin
						cmd.respond = 1'b1;
						cmd.query   = 1'b1;
					end
					OP_STAGE: begin
						if (stat.lfound) begin
							cmd.respond = 1'b1;
							cmd.status  = ST_CONFLICT;
						end else if (stat.sempty) begin
							cmd.respond  = 1'b1;
							cmd.stage_wr = 1'b1;
						end else begin
							cmd.sscan = 1'b1;
							state_d   = S_SSCAN;
						end
					end
					default: begin
						cmd.respond = 1'b1;
					end
				endcase
			end
			S_SSCAN: begin
				if (stat.sdone) begin
					state_d = S_SDEC;
				end
			end
			S_SDEC: begin
				state_d     = S_IDLE;
				cmd.respond = 1'b1;
				if (stat.sfound) begin
					cmd.status = ST_CONFLICT;
				end else if (stat.sfull) begin
					cmd.status = ST_STAGE_FULL;
				end else begin
					cmd.stage_wr = 1'b1;
				end
			end
			S_PUB_RD: begin
				// staged read is issued at the publish cursor
				if (stat.pub_more) begin
					state_d = S_PUB_LD;
				end else begin
					cmd.set_flag = 1'b1;
					cmd.respond  = 1'b1;
					cmd.status   = lfull_q ? ST_LIVE_FULL : ST_OK;
					state_d      = S_IDLE;
				end
			end
			S_PUB_LD: begin
				cmd.pub_ld = 1'b1;
				cmd.lscan  = 1'b1;
				state_d    = S_PUB_SCAN;
			end
			S_PUB_SCAN: begin
				if (stat.ldone) begin
					state_d = S_PUB_DEC;
				end
			end
			S_PUB_DEC: begin
				cmd.live_wr  = !stat.lfound && stat.lfree;
				cmd.pub_next = 1'b1;
				state_d      = S_PUB_RD;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	a_one_resp: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.respond |=> !busy)
		else $error("response issued while work continues");
	a_no_wr_clr: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.live_wr && cmd.live_clr))
		else $error("live write and clear together");
	a_idle_start: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_in |-> state_q == S_IDLE)
		else $error("request loaded outside idle");

endmodule

/* hdl/spent_output_set_with_staging.sv */
// ----------------------------------------------------------------------------
// spent_output_set_with_staging: spent output set with attempt staging
// Live set of spent keys with chain tags, plus a staging list published once.
// ----------------------------------------------------------------------------
//  channel   ports              handshake
//  request   req (req_t)        taken when start high and busy low
//  result    rsp (rsp_t)        valid for one cycle while strobe is high
//
//  Record, revert and query scan the live table, one slot a cycle through
//  the RAM read port. Stage adds a scan of the staging list when the key
//  is not live and the list is not empty. Publish runs a live scan for
//  every staged word. Begin and repeated publish answer straight from idle.
//  Reset clears valid bits, counts and flags at once; no clearing pass.
//  The result is shown for one cycle and cannot be held off.
module spent_output_set_with_staging
	import sos_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  req_t req,
	output logic busy,
	output logic strobe,
	output rsp_t rsp
);

	cmd_t  cmd;
	stat_t stat;

	sos_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.op    (req.op),
		.stat  (stat),
		.cmd   (cmd),
		.busy  (busy)
	);

	sos_dp u_dp (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.cmd   (cmd),
		.stat  (stat),
		.strobe(strobe),
		.rsp   (rsp)
	);

endmodule
